### rtl/core/tcp_client_connection_fsm_unit_macros.svh
// assertion macros for the tcp client connection block
// used by the top level only; needs nothing else
`ifndef TCP_CLIENT_CONNECTION_FSM_UNIT_MACROS_SVH
`define TCP_CLIENT_CONNECTION_FSM_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcf_pkg.sv
// types, codes and constants of the tcp client connection block
// no dependencies; used by tcf_front, tcf_queue, tcf_back and the top level
package tcf_pkg;

  // event codes of an input item
  typedef enum logic [2:0] {
    OP_SEGMENT   = 3'd0,
    OP_ARP_REPLY = 3'd1,
    OP_REQ_ARP   = 3'd2,
    OP_REQ_ACK   = 3'd3,
    OP_REQ_FIN   = 3'd4,
    OP_SERVICE   = 3'd5,
    OP_TICK      = 3'd6,
    OP_RESTART   = 3'd7
  } tcf_op_t;

  // connection states
  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_SYN_SENT    = 4'd1,
    ST_ESTABLISHED = 4'd2,
    ST_CLOSE_WAIT  = 4'd3,
    ST_FIN_WAIT1   = 4'd4,
    ST_FIN_WAIT2   = 4'd5,
    ST_CLOSING     = 4'd6,
    ST_TIME_WAIT   = 4'd7,
    ST_LAST_ACK    = 4'd8
  } tcf_conn_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ARP    = 2'd1,
    KIND_SEG    = 2'd2
  } tcf_kind_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PORT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  // configuration reset values
  localparam logic [15:0] INIT_PORT_RST   = 16'd49152;
  localparam logic [15:0] REMOTE_PORT_RST = 16'd80;
  localparam logic [7:0]  TIMEOUT_RST     = 8'd5;

  // tcp flag bits
  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_RST_BIT = 2;
  localparam int FLAG_ACK_BIT = 4;
  localparam logic [5:0] FLAGS_NONE    = 6'h00;
  localparam logic [5:0] FLAGS_SYN     = 6'h02;
  localparam logic [5:0] FLAGS_ACK     = 6'h10;
  localparam logic [5:0] FLAGS_FIN_ACK = 6'h11;

  // pending-send mark bits, in service order
  localparam int MARK_ARP = 0;
  localparam int MARK_SYN = 1;
  localparam int MARK_ACK = 2;
  localparam int MARK_FIN = 3;

  // default job queue depth
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // input item
  typedef struct packed {
    tcf_op_t     opcode;
    logic [5:0]  in_flags;
    logic [31:0] in_seq;
    logic [31:0] in_ack;
    logic [47:0] sender_mac;
  } tcf_in_t;

  // result item
  typedef struct packed {
    tcf_kind_t   kind;
    logic [5:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [47:0] dest_mac;
    tcf_conn_t   conn_state;
    logic        link_led;
    logic        last;
  } tcf_out_t;

  // job handed from the front to the back: a snapshot after the event
  typedef struct packed {
    logic [3:0]  marks;       // messages to send, zero for a status result
    tcf_conn_t   state_pre;   // state reported with an arp request
    tcf_conn_t   state;       // state after the event
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] port;
    logic [47:0] mac;
    logic        led;
  } tcf_job_t;

  // configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } tcf_cfg_wr_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } tcf_q_stat_t;

endpackage

### rtl/core/tcf_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from tcf_pkg
interface tcf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/tcf_front.sv
// front part: accepts events, keeps the connection state and config registers
// depends on tcf_pkg and tcf_stream_if; pushes jobs into tcf_queue
module tcf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  tcf_stream_if.sink            in_ch,
  input  tcf_pkg::tcf_cfg_wr_t  cfg_wr,
  input  tcf_pkg::tcf_q_stat_t  q_stat,
  output logic                  q_push,
  output tcf_pkg::tcf_job_t     q_job,
  output logic [15:0]           remote_port
);

  // configuration registers
  logic [15:0] remote_port_r;
  logic [7:0]  timeout_r;

  // connection state
  tcf_pkg::tcf_conn_t state_r, state_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;
  logic [15:0] port_r, port_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [3:0]  marks_r, marks_nxt;
  logic        armed_r, armed_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        led_r, led_nxt;

  tcf_pkg::tcf_in_t ev;
  logic fl_fin, fl_syn, fl_rst, fl_ack;

  assign ev      = in_ch.payload;
  assign fl_fin  = ev.in_flags[tcf_pkg::FLAG_FIN_BIT];
  assign fl_syn  = ev.in_flags[tcf_pkg::FLAG_SYN_BIT];
  assign fl_rst  = ev.in_flags[tcf_pkg::FLAG_RST_BIT];
  assign fl_ack  = ev.in_flags[tcf_pkg::FLAG_ACK_BIT];

  // accept whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign remote_port = remote_port_r;

  // configuration registers; the initial port goes straight into the local port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_port_r <= tcf_pkg::REMOTE_PORT_RST;
      timeout_r     <= tcf_pkg::TIMEOUT_RST;
    end else if (cfg_wr.we) begin
      case (cfg_wr.idx)
        tcf_pkg::CFG_REMOTE_PORT: remote_port_r <= cfg_wr.data;
        tcf_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  // next state of the connection for an accepted event
  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    port_nxt  = port_r;
    mac_nxt   = mac_r;
    marks_nxt = marks_r;
    armed_nxt = armed_r;
    count_nxt = count_r;
    led_nxt   = led_r;
    if (q_push) begin
      case (ev.opcode)
        tcf_pkg::OP_SEGMENT: begin
          if (fl_rst) begin
            state_nxt = tcf_pkg::ST_CLOSED;
            port_nxt  = port_r + 16'd1;
          end else begin
            case (state_r)
              tcf_pkg::ST_SYN_SENT: begin
                if (fl_ack && fl_syn) begin
                  ack_nxt   = ev.in_seq + 32'd1;
                  seq_nxt   = ev.in_ack;
                  armed_nxt = 1'b0;
                  state_nxt = tcf_pkg::ST_ESTABLISHED;
                  led_nxt   = 1'b1;
                  marks_nxt[tcf_pkg::MARK_ACK] = 1'b1;
                end
              end
              tcf_pkg::ST_ESTABLISHED: begin
                // peer close passes through close wait in the same event
                if (fl_fin) begin
                  ack_nxt   = ev.in_seq + 32'd1;
                  seq_nxt   = ev.in_ack;
                  marks_nxt[tcf_pkg::MARK_ACK] = 1'b1;
                  marks_nxt[tcf_pkg::MARK_FIN] = 1'b1;
                  state_nxt = tcf_pkg::ST_LAST_ACK;
                end
              end
              tcf_pkg::ST_CLOSE_WAIT: begin
                ack_nxt   = ev.in_seq + 32'd1;
                seq_nxt   = ev.in_ack;
                marks_nxt[tcf_pkg::MARK_FIN] = 1'b1;
                state_nxt = tcf_pkg::ST_LAST_ACK;
              end
              tcf_pkg::ST_FIN_WAIT1: begin
                if (fl_fin) begin
                  marks_nxt[tcf_pkg::MARK_ACK] = 1'b1;
                  state_nxt = tcf_pkg::ST_CLOSING;
                end else if (fl_ack) begin
                  state_nxt = tcf_pkg::ST_FIN_WAIT2;
                end
              end
              tcf_pkg::ST_FIN_WAIT2: begin
                if (fl_fin) begin
                  marks_nxt[tcf_pkg::MARK_ACK] = 1'b1;
                  state_nxt = tcf_pkg::ST_TIME_WAIT;
                end
              end
              tcf_pkg::ST_CLOSING: begin
                if (fl_ack) begin
                  state_nxt = tcf_pkg::ST_TIME_WAIT;
                end
              end
              tcf_pkg::ST_LAST_ACK: begin
                if (fl_ack) begin
                  led_nxt   = 1'b0;
                  state_nxt = tcf_pkg::ST_CLOSED;
                  port_nxt  = port_r + 16'd1;
                end
              end
              default: ;
            endcase
          end
        end
        tcf_pkg::OP_ARP_REPLY: begin
          if (state_r == tcf_pkg::ST_CLOSED) begin
            mac_nxt = ev.sender_mac;
            marks_nxt[tcf_pkg::MARK_SYN] = 1'b1;
          end
        end
        tcf_pkg::OP_REQ_ARP: marks_nxt[tcf_pkg::MARK_ARP] = 1'b1;
        tcf_pkg::OP_REQ_ACK: marks_nxt[tcf_pkg::MARK_ACK] = 1'b1;
        tcf_pkg::OP_REQ_FIN: marks_nxt[tcf_pkg::MARK_FIN] = 1'b1;
        tcf_pkg::OP_SERVICE: begin
          // every pending message goes out, the back expands them
          if (marks_r[tcf_pkg::MARK_ARP]) begin
            armed_nxt = 1'b1;
            count_nxt = timeout_r;
          end
          if (marks_r[tcf_pkg::MARK_SYN]) begin
            state_nxt = tcf_pkg::ST_SYN_SENT;
          end
          marks_nxt = 4'd0;
        end
        tcf_pkg::OP_TICK: begin
          if (armed_r) begin
            if (count_r <= 8'd1) begin
              armed_nxt = 1'b0;
              count_nxt = 8'd0;
              marks_nxt = 4'd0;
              state_nxt = tcf_pkg::ST_CLOSED;
            end else begin
              count_nxt = count_r - 8'd1;
            end
          end
        end
        tcf_pkg::OP_RESTART: begin
          marks_nxt = 4'd0;
          state_nxt = tcf_pkg::ST_CLOSED;
        end
        default: ;
      endcase
    end
    // a write of the initial port loads the local port at once
    if (cfg_wr.we && cfg_wr.idx == tcf_pkg::CFG_INIT_PORT) begin
      port_nxt = cfg_wr.data;
    end
  end

  // job snapshot for the back
  always_comb begin
    q_job.marks     = (ev.opcode == tcf_pkg::OP_SERVICE) ? marks_r : 4'd0;
    q_job.state_pre = state_r;
    q_job.state     = state_nxt;
    q_job.seq       = seq_nxt;
    q_job.ack       = ack_nxt;
    q_job.port      = port_nxt;
    q_job.mac       = mac_nxt;
    q_job.led       = led_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcf_pkg::ST_CLOSED;
      seq_r   <= 32'd0;
      ack_r   <= 32'd0;
      port_r  <= tcf_pkg::INIT_PORT_RST;
      mac_r   <= 48'd0;
      marks_r <= 4'd0;
      armed_r <= 1'b0;
      count_r <= 8'd0;
      led_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      port_r  <= port_nxt;
      mac_r   <= mac_nxt;
      marks_r <= marks_nxt;
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

### rtl/core/tcf_queue.sv
// short job queue between the front and the back
// depends on tcf_pkg for the job and status types
module tcf_queue #(
  parameter int DEPTH = tcf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tcf_pkg::tcf_job_t    push_job,
  input  logic                 pop,
  output tcf_pkg::tcf_job_t    head,
  output tcf_pkg::tcf_q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcf_pkg::tcf_job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign head           = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/core/tcf_back.sv
// back part: expands a job into its result items, one per cycle while the receiver takes them
// depends on tcf_pkg and tcf_stream_if; pops jobs from tcf_queue
module tcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcf_pkg::tcf_job_t    head,
  input  tcf_pkg::tcf_q_stat_t q_stat,
  input  logic [15:0]          remote_port,
  output logic                 q_pop,
  tcf_stream_if.source         out_ch
);

  logic [3:0] done_r, done_nxt;
  logic [3:0] rem;
  logic [3:0] sel;
  logic       is_last;
  logic       load;
  tcf_pkg::tcf_out_t res;
  tcf_pkg::tcf_out_t out_r;
  logic       out_valid_r;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // output register loads when a job waits and it is empty or being taken
  assign load    = q_stat.not_empty && (!out_valid_r || out_ch.ready);
  assign rem     = head.marks & ~done_r;
  assign sel     = rem & (~rem + 4'd1);
  assign is_last = ((rem & ~sel) == 4'd0);
  assign q_pop   = load && is_last;

  // build the next result from the lowest pending message
  always_comb begin
    res.out_seq     = head.seq;
    res.out_ack     = head.ack;
    res.source_port = head.port;
    res.dest_port   = remote_port;
    res.dest_mac    = head.mac;
    res.link_led    = head.led;
    res.last        = is_last;
    res.conn_state  = head.state;
    res.kind        = tcf_pkg::KIND_SEG;
    res.out_flags   = tcf_pkg::FLAGS_NONE;
    if (sel[tcf_pkg::MARK_ARP]) begin
      res.kind       = tcf_pkg::KIND_ARP;
      res.conn_state = head.state_pre;
    end else if (sel[tcf_pkg::MARK_SYN]) begin
      res.out_flags = tcf_pkg::FLAGS_SYN;
    end else if (sel[tcf_pkg::MARK_ACK]) begin
      res.out_flags = tcf_pkg::FLAGS_ACK;
    end else if (sel[tcf_pkg::MARK_FIN]) begin
      res.out_flags = tcf_pkg::FLAGS_FIN_ACK;
    end else begin
      res.kind = tcf_pkg::KIND_STATUS;
    end
  end

  // messages already sent for the head job
  always_comb begin
    done_nxt = done_r;
    if (load) begin
      done_nxt = is_last ? 4'd0 : (done_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

endmodule

### rtl/core/tcp_client_connection_fsm_unit.sv
// top level of the tcp client connection block
// depends on tcf_pkg, tcf_stream_if, tcf_front, tcf_queue, tcf_back and the macros header
//
// Each event is taken by the front, which updates the connection state at
// once and queues a job; the back turns a job into its results at one transfer
// per cycle while the receiver takes them, so a service call yields one to four
// results and any other event one. Input is taken whenever the job queue
// (QUEUE_DEPTH entries) has room, so events keep flowing while results wait at
// the output register; sustained throughput is set by the output side at one
// result per cycle. Configuration writes take effect at the next clock edge and
// must be made while no results are outstanding.
`include "tcp_client_connection_fsm_unit_macros.svh"

module tcp_client_connection_fsm_unit #(
  parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tcf_stream_if.sink                       in_ch,
  tcf_stream_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tcf_pkg::tcf_cfg_wr_t cfg_wr;
  tcf_pkg::tcf_q_stat_t q_stat;
  tcf_pkg::tcf_job_t    q_job;
  tcf_pkg::tcf_job_t    q_head;
  logic                 q_push;
  logic                 q_pop;
  logic [15:0]          remote_port;

  // handshake and payload views for the checks
  logic                 job_held;
  logic                 out_fire;
  logic                 out_last;
  logic                 out_is_status;
  logic                 out_is_arp;
  logic                 arp_flags_ok;

  assign cfg_wr.we   = cfg_we;
  assign cfg_wr.idx  = cfg_idx;
  assign cfg_wr.data = cfg_wdata;

  // event intake and connection state
  tcf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr      (cfg_wr),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (q_job),
    .remote_port (remote_port)
  );

  // job queue
  tcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // result generation
  tcf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_stat      (q_stat),
    .remote_port (remote_port),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

  assign job_held      = q_stat.not_empty || out_ch.valid;
  assign out_fire      = out_ch.valid && out_ch.ready;
  assign out_last      = out_ch.payload.last;
  assign out_is_status = out_ch.valid && (out_ch.payload.kind == tcf_pkg::KIND_STATUS);
  assign out_is_arp    = out_ch.valid && (out_ch.payload.kind == tcf_pkg::KIND_ARP);
  assign arp_flags_ok  = (out_ch.payload.out_flags == tcf_pkg::FLAGS_NONE);

  // a transferred event leaves a job or its results behind
  `TCF_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, job_held, "job lost after transfer")

  // results of one job follow without a gap
  `TCF_ASSERT_NEXT(a_no_gap, clk, rst_n, out_fire && !out_last, out_ch.valid, "gap inside a job")

  // a status result stands alone
  `TCF_ASSERT_NOW(a_status_last, clk, rst_n, out_is_status, out_last, "status result not last")

  // arp requests carry no tcp flags
  `TCF_ASSERT_NOW(a_arp_flags, clk, rst_n, out_is_arp, arp_flags_ok, "flags on arp request")

endmodule

### dv/tcp_client_connection_fsm_unit_test.sv
// self-checking testbench for the tcp client connection block: directed events, then
// connection sessions and random events across register settings, checked by a predictor
// depends on tcf_pkg, tcf_stream_if and tcp_client_connection_fsm_unit
`timescale 1ns / 1ps

module tcp_client_connection_fsm_unit_test;
  import tcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASE_EVENTS = 75;
  localparam int PHASES = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [5:0] FIN_FLAG = 6'b1 << FLAG_FIN_BIT;
  localparam logic [5:0] SYN_FLAG = 6'b1 << FLAG_SYN_BIT;
  localparam logic [5:0] RST_FLAG = 6'b1 << FLAG_RST_BIT;
  localparam logic [5:0] ACK_FLAG = 6'b1 << FLAG_ACK_BIT;
  localparam logic [31:0] WORD_ALL = 32'hFFFF_FFFF;
  localparam logic [47:0] MAC_ALL = 48'hFFFF_FFFF_FFFF;
  localparam tcf_out_t NO_WANT = '0;

  typedef struct {
    tcf_in_t  ev;
    bit       typed;
    tcf_out_t want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcf_stream_if #(.payload_t(tcf_in_t))  in_ch ();
  tcf_stream_if #(.payload_t(tcf_out_t)) out_ch ();

  tcp_client_connection_fsm_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predicted connection state and register copies
  tcf_conn_t   conn_q;
  logic [31:0] seq_q;
  logic [31:0] ack_q;
  logic [15:0] lport_q;
  logic [15:0] init_port_q;
  logic [15:0] rport_q;
  logic [7:0]  tmo_q;
  logic [7:0]  tick_q;
  logic [47:0] mac_q;
  logic [3:0]  marks_q;
  logic        armed_q;
  logic        led_q;

  tcf_out_t    awaited_results[$];
  script_row_t directed_rows[$];

  int events_sent;
  int results_checked;
  int mismatches;
  int quiet_cycles;
  int long_holds;
  bit long_hold_req;
  bit calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one result word built from the current predicted state
  function automatic tcf_out_t snapshot(tcf_kind_t k, logic [5:0] fl);
    tcf_out_t r;
    r.kind        = k;
    r.out_flags   = fl;
    r.out_seq     = seq_q;
    r.out_ack     = ack_q;
    r.source_port = lport_q;
    r.dest_port   = rport_q;
    r.dest_mac    = mac_q;
    r.conn_state  = conn_q;
    r.link_led    = led_q;
    r.last        = 1'b0;
    return r;
  endfunction

  // advance the predicted connection by one event and queue its results
  function automatic int step_connection(tcf_in_t ev);
    tcf_out_t   batch[4];
    logic [5:0] fl;
    int         n;
    int         i;
    n  = 0;
    fl = ev.in_flags;
    case (ev.opcode)
      OP_SEGMENT: begin
        if (fl[FLAG_RST_BIT]) begin
          conn_q  = ST_CLOSED;
          lport_q = lport_q + 16'd1;
        end else begin
          case (conn_q)
            ST_SYN_SENT: begin
              if (fl[FLAG_ACK_BIT] && fl[FLAG_SYN_BIT]) begin
                ack_q   = ev.in_seq + 32'd1;
                seq_q   = ev.in_ack;
                armed_q = 1'b0;
                conn_q  = ST_ESTABLISHED;
                led_q   = 1'b1;
                marks_q[MARK_ACK] = 1'b1;
              end
            end
            ST_ESTABLISHED: begin
              // peer close: passes through close wait straight to last ack
              if (fl[FLAG_FIN_BIT]) begin
                ack_q  = ev.in_seq + 32'd1;
                seq_q  = ev.in_ack;
                marks_q[MARK_ACK] = 1'b1;
                marks_q[MARK_FIN] = 1'b1;
                conn_q = ST_LAST_ACK;
              end
            end
            ST_CLOSE_WAIT: begin
              ack_q  = ev.in_seq + 32'd1;
              seq_q  = ev.in_ack;
              marks_q[MARK_FIN] = 1'b1;
              conn_q = ST_LAST_ACK;
            end
            ST_FIN_WAIT1: begin
              if (fl[FLAG_ACK_BIT]) conn_q = ST_FIN_WAIT2;
              if (fl[FLAG_FIN_BIT]) begin
                marks_q[MARK_ACK] = 1'b1;
                conn_q = ST_CLOSING;
              end
            end
            ST_FIN_WAIT2: begin
              if (fl[FLAG_FIN_BIT]) begin
                marks_q[MARK_ACK] = 1'b1;
                conn_q = ST_TIME_WAIT;
              end
            end
            ST_CLOSING: begin
              if (fl[FLAG_ACK_BIT]) conn_q = ST_TIME_WAIT;
            end
            ST_LAST_ACK: begin
              if (fl[FLAG_ACK_BIT]) begin
                led_q   = 1'b0;
                conn_q  = ST_CLOSED;
                lport_q = lport_q + 16'd1;
              end
            end
            default: ;
          endcase
        end
      end
      OP_ARP_REPLY: begin
        if (conn_q == ST_CLOSED) begin
          mac_q = ev.sender_mac;
          marks_q[MARK_SYN] = 1'b1;
        end
      end
      OP_REQ_ARP: marks_q[MARK_ARP] = 1'b1;
      OP_REQ_ACK: marks_q[MARK_ACK] = 1'b1;
      OP_REQ_FIN: marks_q[MARK_FIN] = 1'b1;
      OP_SERVICE: begin
        // pending messages leave in fixed order
        if (marks_q[MARK_ARP]) begin
          marks_q[MARK_ARP] = 1'b0;
          armed_q  = 1'b1;
          tick_q   = tmo_q;
          batch[n] = snapshot(KIND_ARP, FLAGS_NONE);
          n++;
        end
        if (marks_q[MARK_SYN]) begin
          conn_q   = ST_SYN_SENT;
          marks_q[MARK_SYN] = 1'b0;
          batch[n] = snapshot(KIND_SEG, FLAGS_SYN);
          n++;
        end
        if (marks_q[MARK_ACK]) begin
          marks_q[MARK_ACK] = 1'b0;
          batch[n] = snapshot(KIND_SEG, FLAGS_ACK);
          n++;
        end
        if (marks_q[MARK_FIN]) begin
          marks_q[MARK_FIN] = 1'b0;
          batch[n] = snapshot(KIND_SEG, FLAGS_FIN_ACK);
          n++;
        end
      end
      OP_TICK: begin
        // connect timeout: expiry abandons the attempt
        if (armed_q) begin
          if (tick_q <= 8'd1) begin
            armed_q = 1'b0;
            tick_q  = 8'd0;
            marks_q = 4'd0;
            conn_q  = ST_CLOSED;
          end else begin
            tick_q = tick_q - 8'd1;
          end
        end
      end
      default: begin
        marks_q = 4'd0;
        conn_q  = ST_CLOSED;
      end
    endcase
    if (n == 0) begin
      batch[0] = snapshot(KIND_STATUS, FLAGS_NONE);
      n = 1;
    end
    batch[n-1].last = 1'b1;
    for (i = 0; i < n; i++) awaited_results.push_back(batch[i]);
    return n;
  endfunction

  // status word for the directed rows whose result is plain to see
  function automatic tcf_out_t status_of(logic [31:0] sq, logic [31:0] ak, logic [15:0] port,
                                         logic [47:0] mac, tcf_conn_t st, logic led);
    tcf_out_t r;
    r.kind        = KIND_STATUS;
    r.out_flags   = FLAGS_NONE;
    r.out_seq     = sq;
    r.out_ack     = ak;
    r.source_port = port;
    r.dest_port   = REMOTE_PORT_RST;
    r.dest_mac    = mac;
    r.conn_state  = st;
    r.link_led    = led;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic tcf_in_t ev_of(tcf_op_t op, logic [5:0] fl, logic [31:0] sq,
                                    logic [31:0] ak, logic [47:0] mac);
    tcf_in_t ev;
    ev.opcode     = op;
    ev.in_flags   = fl;
    ev.in_seq     = sq;
    ev.in_ack     = ak;
    ev.sender_mac = mac;
    return ev;
  endfunction

  // random event of a given kind, with flag bits forced on and off
  function automatic tcf_in_t make_event(tcf_op_t op, logic [5:0] set, logic [5:0] clr);
    logic [5:0] fl;
    fl = 6'($urandom());
    return ev_of(op, (fl | set) & ~clr, $urandom(), $urandom(),
                 48'({$urandom(), $urandom()}));
  endfunction

  function automatic void compare_result(tcf_out_t got, tcf_out_t want);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.out_flags !== want.out_flags) begin
      $error("out_flags: expected 0x%0h, got 0x%0h", want.out_flags, got.out_flags);
      mismatches++;
    end
    if (got.out_seq !== want.out_seq) begin
      $error("out_seq: expected 0x%0h, got 0x%0h", want.out_seq, got.out_seq);
      mismatches++;
    end
    if (got.out_ack !== want.out_ack) begin
      $error("out_ack: expected 0x%0h, got 0x%0h", want.out_ack, got.out_ack);
      mismatches++;
    end
    if (got.source_port !== want.source_port) begin
      $error("source_port: expected %0d, got %0d", want.source_port, got.source_port);
      mismatches++;
    end
    if (got.dest_port !== want.dest_port) begin
      $error("dest_port: expected %0d, got %0d", want.dest_port, got.dest_port);
      mismatches++;
    end
    if (got.dest_mac !== want.dest_mac) begin
      $error("dest_mac: expected 0x%0h, got 0x%0h", want.dest_mac, got.dest_mac);
      mismatches++;
    end
    if (got.conn_state !== want.conn_state) begin
      $error("conn_state: expected %0d, got %0d", want.conn_state, got.conn_state);
      mismatches++;
    end
    if (got.link_led !== want.link_led) begin
      $error("link_led: expected %0b, got %0b", want.link_led, got.link_led);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d state %0d", out_ch.payload.kind,
               out_ch.payload.conn_state);
        mismatches++;
      end else begin
        compare_result(out_ch.payload, awaited_results.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without a transfer", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        long_holds++;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offer one event, maybe after a gap; valid stays high for a following event
  task automatic offer_event(tcf_in_t ev);
    int n;
    if (!calm && !long_hold_req && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= ev;
    do @(posedge clk); while (!in_ch.ready);
    n = step_connection(ev);
    events_sent++;
  endtask

  // stop sending and let every awaited result arrive
  task automatic wait_for_quiet();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_INIT_PORT: begin
        init_port_q = data;
        lport_q     = data;
      end
      CFG_REMOTE_PORT: rport_q = data;
      CFG_TIMEOUT:     tmo_q   = data[7:0];
      default: ;
    endcase
  endtask

  // register settings per phase, extremes first
  task automatic retune(int phase);
    wait_for_quiet();
    case (phase)
      0: begin
        load_register(CFG_INIT_PORT, 16'hFFFF);
        load_register(CFG_REMOTE_PORT, 16'h0000);
        load_register(CFG_TIMEOUT, 16'd1);
        load_register(CFG_UNUSED, 16'($urandom()));
      end
      1: begin
        load_register(CFG_INIT_PORT, 16'h0000);
        load_register(CFG_REMOTE_PORT, 16'hFFFF);
        load_register(CFG_TIMEOUT, 16'd255);
      end
      2: begin
        // zero timeout: an armed timer expires on the next tick
        load_register(CFG_INIT_PORT, 16'($urandom()));
        load_register(CFG_REMOTE_PORT, 16'($urandom()));
        load_register(CFG_TIMEOUT, 16'd0);
      end
      3: begin
        load_register(CFG_INIT_PORT, 16'($urandom()));
        load_register(CFG_REMOTE_PORT, 16'($urandom()));
        load_register(CFG_TIMEOUT, 16'($urandom_range(1, 6)));
      end
      default: begin
        load_register(CFG_INIT_PORT, INIT_PORT_RST);
        load_register(CFG_REMOTE_PORT, REMOTE_PORT_RST);
        load_register(CFG_TIMEOUT, 16'(TIMEOUT_RST));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // a well-formed open and close with random content, some of it broken
  task automatic run_session();
    offer_event(make_event(OP_RESTART, 6'h00, 6'h00));
    offer_event(make_event(OP_REQ_ARP, 6'h00, 6'h00));
    if ($urandom_range(0, 5) == 0) begin
      offer_event(make_event(tcf_op_t'($urandom_range(0, 7)), 6'h00, 6'h00));
    end
    offer_event(make_event(OP_SERVICE, 6'h00, 6'h00));
    repeat ($urandom_range(0, 2)) offer_event(make_event(OP_TICK, 6'h00, 6'h00));
    offer_event(make_event(OP_ARP_REPLY, 6'h00, 6'h00));
    offer_event(make_event(OP_SERVICE, 6'h00, 6'h00));
    if ($urandom_range(0, 4) == 0) begin
      offer_event(make_event(OP_SEGMENT, SYN_FLAG, ACK_FLAG | RST_FLAG));
    end
    offer_event(make_event(OP_SEGMENT, SYN_FLAG | ACK_FLAG, RST_FLAG));
    if ($urandom_range(0, 2) == 0) offer_event(make_event(OP_REQ_ACK, 6'h00, 6'h00));
    offer_event(make_event(OP_SERVICE, 6'h00, 6'h00));
    case ($urandom_range(0, 3))
      0, 1: begin
        // peer closes, we answer and wait for the final ack
        offer_event(make_event(OP_SEGMENT, FIN_FLAG, RST_FLAG));
        offer_event(make_event(OP_SERVICE, 6'h00, 6'h00));
        offer_event(make_event(OP_SEGMENT, ACK_FLAG, RST_FLAG));
      end
      2: begin
        offer_event(make_event(OP_REQ_FIN, 6'h00, 6'h00));
        offer_event(make_event(OP_SERVICE, 6'h00, 6'h00));
        offer_event(make_event(OP_SEGMENT, RST_FLAG, 6'h00));
      end
      default: begin
        offer_event(make_event(OP_SEGMENT, ACK_FLAG, FIN_FLAG | RST_FLAG));
        offer_event(make_event(OP_TICK, 6'h00, 6'h00));
        offer_event(make_event(OP_RESTART, 6'h00, 6'h00));
      end
    endcase
  endtask

  // main sequence
  initial begin
    int phase;
    int phase_start;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    quiet_cycles  = 0;
    long_hold_req = 1'b0;
    calm          = 1'b0;

    // predicted state after reset
    init_port_q = INIT_PORT_RST;
    rport_q     = REMOTE_PORT_RST;
    tmo_q       = TIMEOUT_RST;
    conn_q      = ST_CLOSED;
    seq_q       = '0;
    ack_q       = '0;
    lport_q     = INIT_PORT_RST;
    mac_q       = '0;
    marks_q     = '0;
    armed_q     = 1'b0;
    tick_q      = '0;
    led_q       = 1'b0;

    // directed events, default registers
    directed_rows.push_back('{ev_of(OP_TICK, 6'h00, 32'd0, 32'd0, 48'd0), 1'b1,
      status_of(32'd0, 32'd0, 16'd49152, 48'd0, ST_CLOSED, 1'b0)});
    directed_rows.push_back('{ev_of(OP_SERVICE, 6'h00, 32'd0, 32'd0, 48'd0), 1'b1,
      status_of(32'd0, 32'd0, 16'd49152, 48'd0, ST_CLOSED, 1'b0)});
    directed_rows.push_back('{ev_of(OP_SEGMENT, 6'h3F, WORD_ALL, WORD_ALL, MAC_ALL), 1'b1,
      status_of(32'd0, 32'd0, 16'd49153, 48'd0, ST_CLOSED, 1'b0)});
    directed_rows.push_back('{ev_of(OP_RESTART, 6'h3F, WORD_ALL, WORD_ALL, MAC_ALL), 1'b1,
      status_of(32'd0, 32'd0, 16'd49153, 48'd0, ST_CLOSED, 1'b0)});
    directed_rows.push_back('{ev_of(OP_REQ_ARP, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SERVICE, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_TICK, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_ARP_REPLY, 6'h00, 32'd0, 32'd0, MAC_ALL), 1'b1,
      status_of(32'd0, 32'd0, 16'd49153, MAC_ALL, ST_CLOSED, 1'b0)});
    directed_rows.push_back('{ev_of(OP_SERVICE, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SEGMENT, SYN_FLAG, WORD_ALL, WORD_ALL, 48'd0), 1'b0,
      NO_WANT});
    directed_rows.push_back('{ev_of(OP_SEGMENT, SYN_FLAG | ACK_FLAG, WORD_ALL, 32'd0, 48'd0),
      1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_ARP_REPLY, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SEGMENT, ACK_FLAG, 32'd5, 32'd6, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SEGMENT, FIN_FLAG | ACK_FLAG, 32'h7FFF_FFFF,
      32'h8000_0000, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SERVICE, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SEGMENT, ACK_FLAG, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_ARP_REPLY, 6'h00, 32'd0, 32'd0, 48'h5555_AAAA_0001),
      1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_REQ_ARP, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_REQ_ACK, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_REQ_FIN, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    directed_rows.push_back('{ev_of(OP_SERVICE, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    repeat (5) begin
      directed_rows.push_back('{ev_of(OP_TICK, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});
    end
    directed_rows.push_back('{ev_of(OP_SEGMENT, 6'h00, 32'd0, 32'd0, 48'd0), 1'b0, NO_WANT});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table; typed rows replace the predicted word
    foreach (directed_rows[i]) begin
      offer_event(directed_rows[i].ev);
      if (directed_rows[i].typed) begin
        void'(awaited_results.pop_back());
        awaited_results.push_back(directed_rows[i].want);
      end
    end

    // random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      retune(phase);
      if (phase == 1) long_hold_req = 1'b1;
      if (phase == PHASES - 1) calm = 1'b1;
      phase_start = events_sent;
      while (events_sent - phase_start < PHASE_EVENTS) begin
        if ($urandom_range(0, 3) != 0) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            offer_event(make_event(tcf_op_t'($urandom_range(0, 7)), 6'h00, 6'h00));
          end
        end
      end
    end

    wait_for_quiet();
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      mismatches++;
    end
    $display("sent %0d events (directed table, connection sessions, random noise) over %0d",
             events_sent, PHASES + 1);
    $display("register settings; %0d results compared, %0d long output holds, %0d mismatches",
             results_checked, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
